@@ src/ggvc_pkg.sv @@
package ggvc_pkg;

  // datapath widths
  localparam int XW   = 40;  // cordic x/y and products after scaling
  localparam int ZW   = 21;  // angles, signed Q4.16 radians
  localparam int IDXW = 5;   // cordic step index, table has 17 entries, zero beyond
  localparam int VW   = 18;  // velocity result width

  localparam int ANG_PI      = 205887;
  localparam int ANG_TWO_PI  = 411775;
  localparam int ANG_HALF_PI = 102944;
  localparam int INV_GAIN    = 39797;
  localparam int CLAMP_MAX   = 65536;

  // register reset values
  localparam int RST_MAX_LIN  = 3277;
  localparam int RST_MAX_TURN = 3277;
  localparam int RST_GAIN     = 6554;
  localparam int RST_RADIUS   = 6554;

  typedef enum logic [1:0] {
    KIND_POSE = 2'd0,
    KIND_GOAL = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_MAX_LIN  = 2'd0,
    REG_MAX_TURN = 2'd1,
    REG_GAIN     = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_VEC, S_MDIST, S_DECIDE, S_MX0, S_ROT,
    S_MC, S_MS, S_MT, S_OUT1, S_OUT2
  } state_e;

  // request to the cordic unit
  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_req_t;

  // round(atan(2^-i) * 2^16)
  function automatic logic signed [ZW-1:0] atan_lut(input logic [IDXW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = ZW'(51472);
      5'd1:  r = ZW'(30386);
      5'd2:  r = ZW'(16055);
      5'd3:  r = ZW'(8150);
      5'd4:  r = ZW'(4091);
      5'd5:  r = ZW'(2047);
      5'd6:  r = ZW'(1024);
      5'd7:  r = ZW'(512);
      5'd8:  r = ZW'(256);
      5'd9:  r = ZW'(128);
      5'd10: r = ZW'(64);
      5'd11: r = ZW'(32);
      5'd12: r = ZW'(16);
      5'd13: r = ZW'(8);
      5'd14: r = ZW'(4);
      5'd15: r = ZW'(2);
      5'd16: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // symmetric saturation, limit capped at one
  function automatic logic signed [VW-1:0] clampv(input logic signed [XW-1:0] c,
                                                  input logic [16:0] lim);
    logic [16:0] l;
    logic signed [XW-1:0] a;
    logic signed [XW-1:0] r;
    l = (lim > 17'(CLAMP_MAX)) ? 17'(CLAMP_MAX) : lim;
    a = c[XW-1] ? -c : c;
    if (a > $signed({{(XW-17){1'b0}}, l})) a = $signed({{(XW-17){1'b0}}, l});
    r = c[XW-1] ? -a : a;
    return r[VW-1:0];
  endfunction

endpackage

@@ src/ggvc_if.sv @@
interface ggvc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [15:0] heading;
  modport source (output valid, kind, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, heading, output ready);
endinterface

interface ggvc_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] vel_x;
  logic [17:0] vel_y;
  logic [17:0] vel_turn;
  logic        arrived;
  logic        last;
  modport source (output valid, vel_x, vel_y, vel_turn, arrived, last, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_turn, arrived, last, output ready);
endinterface

interface ggvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ggvc_mul.sv @@
// serial shift-add multiplier, one multiplier bit per cycle, result scaled by 2^-16
module ggvc_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [ggvc_pkg::XW-1:0]  a_i,
  input  logic [15:0]                     b_i,
  output logic                            done_o,
  output logic signed [ggvc_pkg::XW-1:0]  p_o
);
  localparam int PW = ggvc_pkg::XW + 16;

  logic signed [PW-1:0] acc_q, acc_d, a_q, a_d;
  logic [15:0] b_q, b_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  // accumulate one partial product per cycle
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = PW'(a_i);
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q[PW-1:16];
endmodule

@@ src/ggvc_cordic.sv @@
// iterative cordic, one micro-rotation per cycle, vectoring or rotation mode
module ggvc_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ggvc_pkg::cordic_req_t           req_i,
  input  logic signed [ggvc_pkg::XW-1:0]  x_i,
  input  logic signed [ggvc_pkg::XW-1:0]  y_i,
  input  logic signed [ggvc_pkg::ZW-1:0]  z_i,
  output logic                            done_o,
  output logic signed [ggvc_pkg::XW-1:0]  x_o,
  output logic signed [ggvc_pkg::XW-1:0]  y_o,
  output logic signed [ggvc_pkg::ZW-1:0]  z_o
);
  localparam int XW = ggvc_pkg::XW;
  localparam int ZW = ggvc_pkg::ZW;
  localparam int IW = ggvc_pkg::IDXW;

  logic signed [XW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, at;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          rot_q, rot_d, busy_q, busy_d, done_q, done_d, up;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    rot_d  = rot_q;
    busy_d = busy_q;
    done_d = 1'b0;
    xs     = x_q >>> cnt_q;
    ys     = y_q >>> cnt_q;
    at     = ggvc_pkg::atan_lut(cnt_q);
    up     = rot_q ? z_q[ZW-1] : !y_q[XW-1];
    if (req_i.start) begin
      // coarse pre-rotation into the convergence range
      x_d    = x_i;
      y_d    = y_i;
      z_d    = z_i;
      cnt_d  = '0;
      rot_d  = req_i.rotate;
      busy_d = 1'b1;
      if (!req_i.rotate) begin
        if (x_i[XW-1]) begin
          x_d = -x_i;
          y_d = -y_i;
          z_d = y_i[XW-1] ? -ZW'(ggvc_pkg::ANG_PI) : ZW'(ggvc_pkg::ANG_PI);
        end
      end else if (z_i > ZW'(ggvc_pkg::ANG_HALF_PI)) begin
        x_d = -y_i;
        y_d = x_i;
        z_d = z_i - ZW'(ggvc_pkg::ANG_HALF_PI);
      end else if (z_i < -ZW'(ggvc_pkg::ANG_HALF_PI)) begin
        x_d = y_i;
        y_d = -x_i;
        z_d = z_i + ZW'(ggvc_pkg::ANG_HALF_PI);
      end
    end else if (busy_q) begin
      // micro-rotation
      if (up) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == IW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rot_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rot_q  <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
endmodule

@@ src/go_to_goal_velocity_controller.sv @@
// Go-to-goal velocity controller. Pose and goal words update the stored state; a
// control tick while the goal is not reached yields a body-frame velocity command
// and, when the distance falls under arrive_radius, a stop word after it. A goal
// word yields a stop word when it lies inside the radius. Pose words are taken in
// the idle state. A goal word takes a vectoring cordic pass plus one serial
// multiply, a tick two cordic passes of one step a cycle and five serial
// multiplies on one shared shift-add multiplier. Output stalls lengthen the work
// on an item. One item is worked at a time; input is taken again once all result
// words have been delivered.
module go_to_goal_velocity_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ggvc_in_if.sink           in_i,
  ggvc_out_if.source        out_o,
  ggvc_cfg_if.sink          cfg_i
);
  localparam int XW = ggvc_pkg::XW;
  localparam int ZW = ggvc_pkg::ZW;
  localparam int VW = ggvc_pkg::VW;

  ggvc_pkg::state_e state_q, state_d;

  logic [16:0] max_lin_q, max_turn_q;
  logic [15:0] gain_q;
  logic [30:0] radius_q;

  logic signed [31:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d, goal_x_q, goal_x_d;
  logic signed [31:0] goal_y_q, goal_y_d;
  logic signed [15:0] cur_h_q, cur_h_d;
  logic at_goal_q, at_goal_d, tick_q, tick_d, stop_q, stop_d;
  logic signed [XW-1:0] dist_q, dist_d, s_q, s_d;
  logic signed [ZW-1:0] ang_q, ang_d, err_q, err_d;
  logic signed [VW-1:0] vx_q, vx_d, vy_q, vy_d, vt_q, vt_d;
  logic ov_q, ov_d, arr_q, arr_d, last_q, last_d;

  logic signed [32:0] dx, dy;
  logic signed [21:0] wa, wv, wr, we;
  logic [21:0] wav;
  logic stop_now;

  ggvc_pkg::cordic_req_t creq;
  logic signed [XW-1:0] c_x, c_y, co_x, co_y;
  logic signed [ZW-1:0] c_z, co_z;
  logic c_done;

  logic m_start, m_done;
  logic signed [XW-1:0] m_a, m_p;
  logic [15:0] m_b;

  ggvc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .req_i(creq), .x_i(c_x), .y_i(c_y), .z_i(c_z),
    .done_o(c_done), .x_o(co_x), .y_o(co_y), .z_o(co_z)
  );

  ggvc_mul u_mul (
    .clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
    .done_o(m_done), .p_o(m_p)
  );

  // goal offset and heading error wrap
  always_comb begin
    dx  = {goal_x_q[31], goal_x_q} - {cur_x_q[31], cur_x_q};
    dy  = {goal_y_q[31], goal_y_q} - {cur_y_q[31], cur_y_q};
    wa  = {ang_q[ZW-1], ang_q} - {{3{cur_h_q[15]}}, cur_h_q, 3'b000};
    wv  = wa + 22'(ggvc_pkg::ANG_PI);
    wav = wv[21] ? 22'(-wv) : 22'(wv);
    if (wav >= 22'(ggvc_pkg::ANG_TWO_PI)) wav = wav - 22'(ggvc_pkg::ANG_TWO_PI);
    wr  = wv[21] ? -$signed(wav) : $signed(wav);
    we  = wr[21] ? wr + 22'(ggvc_pkg::ANG_PI) : wr - 22'(ggvc_pkg::ANG_PI);
    stop_now = dist_q < $signed({{(XW-31){1'b0}}, radius_q});
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    cur_h_d   = cur_h_q;
    goal_x_d  = goal_x_q;
    goal_y_d  = goal_y_q;
    at_goal_d = at_goal_q;
    tick_d    = tick_q;
    stop_d    = stop_q;
    dist_d    = dist_q;
    ang_d     = ang_q;
    err_d     = err_q;
    s_d       = s_q;
    vx_d      = vx_q;
    vy_d      = vy_q;
    vt_d      = vt_q;
    ov_d      = ov_q;
    arr_d     = arr_q;
    last_d    = last_q;
    creq      = '0;
    c_x       = XW'(dx);
    c_y       = XW'(dy);
    c_z       = '0;
    m_start   = 1'b0;
    m_a       = co_x;
    m_b       = 16'(ggvc_pkg::INV_GAIN);
    in_i.ready = (state_q == ggvc_pkg::S_IDLE);
    unique case (state_q)
      ggvc_pkg::S_IDLE: begin
        if (in_i.valid) begin
          case (ggvc_pkg::kind_e'(in_i.kind))
            ggvc_pkg::KIND_POSE: begin
              cur_x_d = in_i.pos_x;
              cur_y_d = in_i.pos_y;
              cur_h_d = in_i.heading;
            end
            ggvc_pkg::KIND_GOAL: begin
              goal_x_d = in_i.pos_x;
              goal_y_d = in_i.pos_y;
              tick_d   = 1'b0;
              state_d  = ggvc_pkg::S_PREP;
            end
            ggvc_pkg::KIND_TICK: begin
              if (!at_goal_q) begin
                tick_d  = 1'b1;
                state_d = ggvc_pkg::S_PREP;
              end
            end
            default: ;
          endcase
        end
      end
      ggvc_pkg::S_PREP: begin
        if (dx == '0 && dy == '0) begin
          dist_d  = '0;
          ang_d   = '0;
          state_d = ggvc_pkg::S_DECIDE;
        end else begin
          creq.start = 1'b1;
          state_d    = ggvc_pkg::S_VEC;
        end
      end
      ggvc_pkg::S_VEC: begin
        if (c_done) begin
          ang_d   = co_z;
          m_start = 1'b1;
          state_d = ggvc_pkg::S_MDIST;
        end
      end
      ggvc_pkg::S_MDIST: begin
        if (m_done) begin
          dist_d  = m_p;
          state_d = ggvc_pkg::S_DECIDE;
        end
      end
      ggvc_pkg::S_DECIDE: begin
        if (!tick_q) begin
          at_goal_d = stop_now;
          if (stop_now) begin
            vx_d = '0; vy_d = '0; vt_d = '0;
            arr_d = 1'b1; last_d = 1'b1; ov_d = 1'b1;
            state_d = ggvc_pkg::S_OUT2;
          end else begin
            state_d = ggvc_pkg::S_IDLE;
          end
        end else begin
          err_d   = we[ZW-1:0];
          stop_d  = stop_now;
          m_a     = dist_q;
          m_start = 1'b1;
          state_d = ggvc_pkg::S_MX0;
        end
      end
      ggvc_pkg::S_MX0: begin
        if (m_done) begin
          creq.start  = 1'b1;
          creq.rotate = 1'b1;
          c_x         = m_p;
          c_y         = '0;
          c_z         = err_q;
          state_d     = ggvc_pkg::S_ROT;
        end
      end
      ggvc_pkg::S_ROT: begin
        if (c_done) begin
          s_d     = co_y;
          m_a     = co_x;
          m_b     = gain_q;
          m_start = 1'b1;
          state_d = ggvc_pkg::S_MC;
        end
      end
      ggvc_pkg::S_MC: begin
        m_a = s_q;
        m_b = gain_q;
        if (m_done) begin
          vx_d    = ggvc_pkg::clampv(m_p, max_lin_q);
          m_start = 1'b1;
          state_d = ggvc_pkg::S_MS;
        end
      end
      ggvc_pkg::S_MS: begin
        m_a = XW'(err_q);
        m_b = gain_q;
        if (m_done) begin
          vy_d    = ggvc_pkg::clampv(m_p, max_lin_q);
          m_start = 1'b1;
          state_d = ggvc_pkg::S_MT;
        end
      end
      ggvc_pkg::S_MT: begin
        if (m_done) begin
          vt_d      = ggvc_pkg::clampv(m_p, max_turn_q);
          arr_d     = 1'b0;
          last_d    = !stop_q;
          ov_d      = 1'b1;
          at_goal_d = stop_q;
          state_d   = ggvc_pkg::S_OUT1;
        end
      end
      ggvc_pkg::S_OUT1: begin
        if (out_o.ready) begin
          if (stop_q) begin
            vx_d = '0; vy_d = '0; vt_d = '0;
            arr_d = 1'b1; last_d = 1'b1;
            state_d = ggvc_pkg::S_OUT2;
          end else begin
            ov_d    = 1'b0;
            state_d = ggvc_pkg::S_IDLE;
          end
        end
      end
      ggvc_pkg::S_OUT2: begin
        if (out_o.ready) begin
          ov_d    = 1'b0;
          state_d = ggvc_pkg::S_IDLE;
        end
      end
      default: state_d = ggvc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ggvc_pkg::S_IDLE;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      cur_h_q   <= '0;
      goal_x_q  <= '0;
      goal_y_q  <= '0;
      at_goal_q <= 1'b1;
      tick_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      cur_h_q   <= cur_h_d;
      goal_x_q  <= goal_x_d;
      goal_y_q  <= goal_y_d;
      at_goal_q <= at_goal_d;
      tick_q    <= tick_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stop_q <= stop_d;
    dist_q <= dist_d;
    ang_q  <= ang_d;
    err_q  <= err_d;
    s_q    <= s_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    vt_q   <= vt_d;
    arr_q  <= arr_d;
    last_q <= last_d;
  end

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q  <= 17'(ggvc_pkg::RST_MAX_LIN);
      max_turn_q <= 17'(ggvc_pkg::RST_MAX_TURN);
      gain_q     <= 16'(ggvc_pkg::RST_GAIN);
      radius_q   <= 31'(ggvc_pkg::RST_RADIUS);
    end else if (cfg_i.valid) begin
      unique case (ggvc_pkg::reg_idx_e'(cfg_i.index))
        ggvc_pkg::REG_MAX_LIN:  max_lin_q  <= cfg_i.data[16:0];
        ggvc_pkg::REG_MAX_TURN: max_turn_q <= cfg_i.data[16:0];
        ggvc_pkg::REG_GAIN:     gain_q     <= cfg_i.data[15:0];
        ggvc_pkg::REG_RADIUS:   radius_q   <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.vel_x    = vx_q;
  assign out_o.vel_y    = vy_q;
  assign out_o.vel_turn = vt_q;
  assign out_o.arrived  = arr_q;
  assign out_o.last     = last_q;

  // checks
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (state_q == ggvc_pkg::S_OUT1 || state_q == ggvc_pkg::S_OUT2))
    else $error("result word outside output states");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input taken while result pending");
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.arrived) |-> (out_o.vel_x == '0 && out_o.vel_y == '0 &&
                                        out_o.vel_turn == '0 && out_o.last))
    else $error("stop word not zero");
  a_goal_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.arrived) |=> at_goal_q)
    else $error("stop word without at-goal");
endmodule
